// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/ioapic_pkg.sv
// ---------------------------------------------------------------------------
// ioapic_pkg
// Shared constants and types of the I/O interrupt controller register file.
// ---------------------------------------------------------------------------
package ioapic_pkg;

    localparam int ENTRIES = 24;
    localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [7:0]  OFS_SELECT   = 8'h00;
    localparam logic [7:0]  OFS_WINDOW   = 8'h10;
    localparam logic [7:0]  IDX_ID       = 8'h00;
    localparam logic [7:0]  IDX_VERSION  = 8'h01;
    localparam logic [7:0]  IDX_TABLE    = 8'h10;
    localparam logic [8:0]  TABLE_END    = 9'(16 + 2 * ENTRIES);
    localparam logic [7:0]  LAST_ENTRY   = 8'(ENTRIES - 1);
    localparam logic [7:0]  VERSION_RST  = 8'd17;
    localparam logic [16:0] MASK_BIT     = 17'h10000;
    localparam logic [16:0] LOW_WRITABLE = 17'h1AFFF;

    typedef enum logic [2:0] {
        K_SEL,
        K_ID,
        K_VER,
        K_LO,
        K_HI,
        K_ERR
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ENTRY_W-1:0] entry;
    } t_dec;

    typedef struct packed {
        logic               rd;
        logic               wr;
        logic               hi;
        logic [ENTRY_W-1:0] entry;
        logic [16:0]        lo_data;
        logic [7:0]         hi_data;
    } t_tbl_req;

endpackage

// File: hw/rtl/ioapic_if.sv
// ---------------------------------------------------------------------------
// ioapic_req_if / ioapic_rsp_if
// Valid/ready channels carrying bus accesses and their results.
// ---------------------------------------------------------------------------
interface ioapic_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  offset;
    logic [31:0] write_data;

    modport source (output valid, output action, output offset, output write_data,
                    input ready);
    modport sink   (input valid, input action, input offset, input write_data,
                    output ready);
endinterface

interface ioapic_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        access_error;

    modport source (output valid, output read_data, output access_error, input ready);
    modport sink   (input valid, input read_data, input access_error, output ready);
endinterface

// File: hw/rtl/ioapic_decode.sv
// ---------------------------------------------------------------------------
// ioapic_decode
// Maps an access offset and the select register onto a target register.
// ---------------------------------------------------------------------------
module ioapic_decode
    import ioapic_pkg::*;
(
    input  logic [7:0] i_offset,
    input  logic [7:0] i_select,
    output t_dec       o_dec
);

    logic [7:0] rel;

    assign rel = i_select - IDX_TABLE;

    always_comb begin
        o_dec.entry = rel[ENTRY_W:1];
        if (i_offset == OFS_SELECT) begin
            o_dec.kind = K_SEL;
        end else if (i_offset == OFS_WINDOW) begin
            if (i_select == IDX_ID) begin
                o_dec.kind = K_ID;
            end else if (i_select == IDX_VERSION) begin
                o_dec.kind = K_VER;
            end else if ({1'b0, i_select} >= {1'b0, IDX_TABLE} &&
                         {1'b0, i_select} < TABLE_END) begin
                o_dec.kind = i_select[0] ? K_HI : K_LO;
            end else begin
                o_dec.kind = K_ERR;
            end
        end else begin
            o_dec.kind = K_ERR;
        end
    end

endmodule

// File: hw/rtl/ioapic_table.sv
// ---------------------------------------------------------------------------
// ioapic_table
// Redirection table: low and high word memories, registered read.
// ---------------------------------------------------------------------------
module ioapic_table
    import ioapic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tbl_req    i_req,
    output logic [31:0] o_rdata
);

    logic [16:0]        r_mem_lo [ENTRIES];
    logic [7:0]         r_mem_hi [ENTRIES];
    logic [ENTRIES-1:0] r_vld_lo;
    logic [ENTRIES-1:0] r_vld_hi;
    logic [16:0]        r_rd_lo;
    logic [7:0]         r_rd_hi;
    logic               r_rd_lo_vld;
    logic               r_rd_hi_vld;
    logic               r_rd_is_hi;

    always_ff @(posedge i_clk) begin
        if (i_req.wr && !i_req.hi) begin
            r_mem_lo[i_req.entry] <= i_req.lo_data;
        end
        if (i_req.wr && i_req.hi) begin
            r_mem_hi[i_req.entry] <= i_req.hi_data;
        end
        if (i_req.rd) begin
            r_rd_lo    <= r_mem_lo[i_req.entry];
            r_rd_hi    <= r_mem_hi[i_req.entry];
            r_rd_is_hi <= i_req.hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_lo    <= '0;
            r_vld_hi    <= '0;
            r_rd_lo_vld <= 1'b0;
            r_rd_hi_vld <= 1'b0;
        end else begin
            if (i_req.wr && !i_req.hi) begin
                r_vld_lo[i_req.entry] <= 1'b1;
            end
            if (i_req.wr && i_req.hi) begin
                r_vld_hi[i_req.entry] <= 1'b1;
            end
            if (i_req.rd) begin
                r_rd_lo_vld <= r_vld_lo[i_req.entry];
                r_rd_hi_vld <= r_vld_hi[i_req.entry];
            end
        end
    end

    // unwritten entries read as reset: masked low word, zero destination
    always_comb begin
        if (r_rd_is_hi) begin
            o_rdata = {(r_rd_hi_vld ? r_rd_hi : 8'h00), 24'h000000};
        end else begin
            o_rdata = {15'h0000, (r_rd_lo_vld ? (r_rd_lo & LOW_WRITABLE) : MASK_BIT)};
        end
    end

endmodule

// File: hw/rtl/ioapic_redirection_register_file.sv
// ---------------------------------------------------------------------------
// ioapic_redirection_register_file
// Indirect register file of an I/O interrupt controller: select register,
// data window, ID, version and redirection table.
//
//   channel   dir  handshake     payload
//   i_req     in   valid/ready   action, offset, write_data
//   o_rsp     out  valid/ready   read_data, access_error
//   i_cfg_*   in   write enable  version code (8 bits)
//
// One item per cycle sustained while results are taken; an accepted access
// passes the stage-one register and table read port, then the result register.
// Per-entry valid bits make unwritten entries read as reset.
// A stalled result holds the pipeline; ready drops while both stages are full and the result is not taken.
// ---------------------------------------------------------------------------
module ioapic_redirection_register_file
    import ioapic_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ioapic_req_if.sink   i_req,
    ioapic_rsp_if.source o_rsp,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_data
);

    t_dec        dec;
    t_tbl_req    tbl_req;
    logic [31:0] tbl_rdata;
    logic        accept;
    logic        s1_adv;
    logic [31:0] direct_data;
    logic [31:0] n_out_data;

    logic [7:0]  r_select;
    logic [3:0]  r_id;
    logic [7:0]  r_version;
    logic        r_s1_valid;
    t_kind       r_s1_kind;
    logic        r_s1_write;
    logic [31:0] r_s1_data;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_err;

    ioapic_decode u_decode (
        .i_offset (i_req.offset),
        .i_select (r_select),
        .o_dec    (dec)
    );

    ioapic_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rdata (tbl_rdata)
    );

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        tbl_req.rd      = accept && !i_req.action && (dec.kind == K_LO || dec.kind == K_HI);
        tbl_req.wr      = accept && i_req.action && (dec.kind == K_LO || dec.kind == K_HI);
        tbl_req.hi      = (dec.kind == K_HI);
        tbl_req.entry   = dec.entry;
        tbl_req.lo_data = i_req.write_data[16:0] & LOW_WRITABLE;
        tbl_req.hi_data = i_req.write_data[31:24];
    end

    always_comb begin
        unique case (dec.kind)
            K_SEL:   direct_data = {24'h000000, r_select};
            K_ID:    direct_data = {4'h0, r_id, 24'h000000};
            K_VER:   direct_data = {8'h00, LAST_ENTRY, 8'h00, r_version};
            default: direct_data = 32'h00000000;
        endcase
    end

    always_comb begin
        if (r_s1_write || r_s1_kind == K_ERR) begin
            n_out_data = 32'h00000000;
        end else if (r_s1_kind == K_LO || r_s1_kind == K_HI) begin
            n_out_data = tbl_rdata;
        end else begin
            n_out_data = r_s1_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select    <= 8'h00;
            r_id        <= 4'h0;
            r_version   <= VERSION_RST;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_version <= i_cfg_data;
            end
            if (accept && i_req.action && dec.kind == K_SEL) begin
                r_select <= i_req.write_data[7:0];
            end
            if (accept && i_req.action && dec.kind == K_ID) begin
                r_id <= i_req.write_data[27:24];
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= dec.kind;
            r_s1_write <= i_req.action;
            r_s1_data  <= direct_data;
        end
        if (s1_adv) begin
            r_out_data <= n_out_data;
            r_out_err  <= (r_s1_kind == K_ERR);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out_data;
    assign o_rsp.access_error = r_out_err;

endmodule

// File: hw/rtl/ioapic_checker.sv
// ---------------------------------------------------------------------------
// ioapic_checker
// Port-level checks on the register file, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ioapic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_read_data,
    input logic        i_rsp_access_error
);

    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `ASSERT_IMPLY(a_rsp_has_item, i_clk, i_rst_n, $rose(i_rsp_valid), $past(req_acc, 2))
    `ASSERT_IMPLY(a_rst_clears, i_clk, i_rst_n, !$past(i_rst_n), !i_rsp_valid)
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, i_rsp_valid && i_rsp_access_error,
                  i_rsp_read_data == 32'h00000000)

endmodule

bind ioapic_redirection_register_file ioapic_checker u_ioapic_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_read_data    (o_rsp.read_data),
    .i_rsp_access_error (o_rsp.access_error)
);
